FILE: hw/rtl/pfc_pkg.sv
// Shared types and constants for the packet framer with CRC-16.
// Used by the controller, the datapath and the top level.
package pfc_pkg;

  // Default frame and packet sizes
  localparam int PFC_FRAME_BYTES      = 25;
  localparam int PFC_MAX_PACKET_BYTES = 825;

  // CRC-16 settings: MSB first, no reflection, no final xor
  localparam logic [15:0] PFC_CRC_POLY = 16'h5935;
  localparam logic [15:0] PFC_CRC_INIT = 16'hFFFF;

  // What the datapath puts into the output register
  typedef enum logic [2:0] {
    EMIT_OVF,
    EMIT_DATA,
    EMIT_HI,
    EMIT_LO,
    EMIT_PAD
  } emit_kind_t;

  // Controller to datapath command
  typedef struct packed {
    logic       load;
    emit_kind_t kind;
    logic       run_end;
    logic       clear;
  } pfc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic drop;
    logic at_frame_end;
  } pfc_stat_t;

  // Advance the CRC by one byte, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ PFC_CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/pfc_in_if.sv
// Input channel: one payload byte per request with a last-byte flag.
// Stands alone; no package needed.
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/pfc_out_if.sv
// Result channel: one frame byte per request with position and framing flags.
// Stands alone; no package needed.
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_position;
  logic       frame_end;
  logic       end_of_packet;
  logic [5:0] frame_meta;
  logic       overflow_error;
  logic       last_of_run;

  modport source (output valid, output frame_byte, output byte_position, output frame_end,
                  output end_of_packet, output frame_meta, output overflow_error,
                  output last_of_run, input ready);
  modport sink   (input valid, input frame_byte, input byte_position, input frame_end,
                  input end_of_packet, input frame_meta, input overflow_error,
                  input last_of_run, output ready);
endinterface

FILE: hw/rtl/pfc_ctrl.sv
// Framer controller: accepts payload bytes and sequences the CRC and padding tail.
// Depends on pfc_pkg for the command and status types.
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  pfc_stat_t stat,
  output pfc_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_PAD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Take a request only between packets' tails and with room in the output
  assign in_ready = (state_r == S_IDLE) && stat.out_free;

  // Decide the next emit and state
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.kind    = EMIT_DATA;
    cmd.run_end = 1'b0;
    cmd.clear   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (stat.drop) begin
            cmd.kind    = EMIT_OVF;
            cmd.run_end = 1'b1;
            cmd.clear   = in_last;
          end else begin
            cmd.kind    = EMIT_DATA;
            cmd.run_end = !in_last;
            if (in_last) begin
              state_nxt = S_HI;
            end
          end
        end
      end
      S_HI: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.kind  = EMIT_HI;
          state_nxt = S_LO;
        end
      end
      S_LO, S_PAD: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.kind = (state_r == S_LO) ? EMIT_LO : EMIT_PAD;
          if (stat.at_frame_end) begin
            cmd.run_end = 1'b1;
            cmd.clear   = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/pfc_datapath.sv
// Framer datapath: CRC, frame position, counters and the output register.
// Depends on pfc_pkg and drives the result channel through pfc_out_if.
module pfc_datapath
  import pfc_pkg::*;
#(
  parameter int FRAME_BYTES      = PFC_FRAME_BYTES,
  parameter int MAX_PACKET_BYTES = PFC_MAX_PACKET_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  pfc_cmd_t   cmd,
  output pfc_stat_t  stat,
  pfc_out_if.source  out_chan
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int UW = $clog2(FRAME_BYTES + 1);
  localparam int BW = $clog2(MAX_PACKET_BYTES + 4);
  localparam logic [PW-1:0] POS_LAST = PW'(FRAME_BYTES - 1);
  localparam logic [PW+1:0] FRAME_W  = (PW+2)'(FRAME_BYTES);
  localparam logic [BW-1:0] MAX_W    = BW'(MAX_PACKET_BYTES);

  // Packet state
  logic [15:0]   crc_r;
  logic [PW-1:0] pos_r;
  logic [5:0]    cnt_r;
  logic [BW-1:0] bytes_r;
  logic          ovf_r;
  logic [UW-1:0] used_r;
  logic          eop_hi_r;

  // Output register
  logic       ov_r;
  logic [7:0] ob_r;
  logic [4:0] opos_r;
  logic       ofe_r;
  logic       oeop_r;
  logic [5:0] ometa_r;
  logic       oerr_r;
  logic       olor_r;

  logic [PW+1:0] pos_w;
  logic [PW+1:0] lo_sum;
  logic [PW+1:0] lo_pos;
  logic [PW-1:0] pos_inc;
  logic          fend;
  logic          eop_data;
  logic          eop_hi_calc;
  logic [UW-1:0] used_calc;
  logic [15:0]   crc_nxt;
  logic [7:0]    emit_byte;
  logic          emit_eop;
  logic [5:0]    emit_meta;

  // Frame position arithmetic
  assign pos_w       = (PW+2)'(pos_r);
  assign fend        = (pos_r == POS_LAST);
  assign pos_inc     = fend ? '0 : pos_r + 1'b1;
  assign lo_sum      = pos_w + 2'd2;
  assign lo_pos      = (lo_sum >= FRAME_W) ? lo_sum - FRAME_W : lo_sum;
  assign used_calc   = UW'(lo_pos + 1'b1);
  assign eop_data    = in_last_byte && ((pos_w + 2'd3) <= FRAME_W);
  assign eop_hi_calc = (((PW+2)'(pos_inc)) + 2'd2) <= FRAME_W;
  assign crc_nxt     = crc16_byte(crc_r, in_data_byte);

  // Select the byte and final-frame flag for this emit
  always_comb begin
    case (cmd.kind)
      EMIT_DATA: begin
        emit_byte = in_data_byte;
        emit_eop  = eop_data;
      end
      EMIT_HI: begin
        emit_byte = crc_r[15:8];
        emit_eop  = eop_hi_r;
      end
      EMIT_LO: begin
        emit_byte = crc_r[7:0];
        emit_eop  = 1'b1;
      end
      default: begin
        emit_byte = 8'h00;
        emit_eop  = 1'b1;
      end
    endcase
  end

  assign emit_meta = !fend ? 6'd0 : (emit_eop ? 6'(used_r) : cnt_r);

  // Status to the controller
  assign stat.out_free     = !ov_r || out_chan.ready;
  assign stat.drop         = ovf_r || ((bytes_r + BW'(3)) > MAX_W);
  assign stat.at_frame_end = fend;

  // Update packet state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= PFC_CRC_INIT;
      pos_r    <= '0;
      cnt_r    <= '0;
      bytes_r  <= '0;
      ovf_r    <= 1'b0;
      used_r   <= '0;
      eop_hi_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
      if (cmd.load) begin
        ov_r   <= 1'b1;
        olor_r <= cmd.run_end;
        if (cmd.kind == EMIT_OVF) begin
          ob_r    <= 8'h00;
          opos_r  <= 5'd0;
          ofe_r   <= 1'b0;
          oeop_r  <= 1'b0;
          ometa_r <= 6'd0;
          oerr_r  <= 1'b1;
          ovf_r   <= 1'b1;
        end else begin
          ob_r    <= emit_byte;
          opos_r  <= 5'(pos_r);
          ofe_r   <= fend;
          oeop_r  <= emit_eop;
          ometa_r <= emit_meta;
          oerr_r  <= 1'b0;
          pos_r   <= pos_inc;
          if (fend && !emit_eop) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (cmd.kind == EMIT_DATA) begin
            crc_r   <= crc_nxt;
            bytes_r <= bytes_r + 1'b1;
            if (in_last_byte) begin
              used_r   <= used_calc;
              eop_hi_r <= eop_hi_calc;
            end
          end
        end
        // Drop the packet state but eop_hi_r at the packet's end
        if (cmd.clear) begin
          crc_r   <= PFC_CRC_INIT;
          pos_r   <= '0;
          cnt_r   <= '0;
          bytes_r <= '0;
          ovf_r   <= 1'b0;
          used_r  <= '0;
        end
      end
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.frame_byte     = ob_r;
  assign out_chan.byte_position  = opos_r;
  assign out_chan.frame_end      = ofe_r;
  assign out_chan.end_of_packet  = oeop_r;
  assign out_chan.frame_meta     = ometa_r;
  assign out_chan.overflow_error = oerr_r;
  assign out_chan.last_of_run    = olor_r;

endmodule

FILE: hw/rtl/packet_framer_with_crc.sv
// Top level of the packet framer with M17-style CRC-16.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_ctrl and pfc_datapath.
//
// Payload bytes enter one per request and each leaves at once at its place in
// a FRAME_BYTES-long frame, so bytes can stream back to back while the output
// is free. The final byte of a packet is followed by the CRC high and low
// bytes and zero padding to the frame's end: that byte holds the input until
// the tail is out, since the single output register sends one frame byte per
// cycle while the result channel is ready. A byte past the length limit gives
// one flagged result. Full frames carry the frame counter at their last byte,
// the final frame its used byte count. No clearing pass follows reset.
module packet_framer_with_crc
  import pfc_pkg::*;
#(
  parameter int FRAME_BYTES      = PFC_FRAME_BYTES,
  parameter int MAX_PACKET_BYTES = PFC_MAX_PACKET_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  pfc_in_if.sink   in_chan,
  pfc_out_if.source out_chan
);

  pfc_cmd_t  cmd;
  pfc_stat_t stat;

  // Sequence requests and the tail
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_byte),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold packet state and drive results
  pfc_datapath #(
    .FRAME_BYTES      (FRAME_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_chan.data_byte),
    .in_last_byte (in_chan.last_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_chan     (out_chan)
  );

endmodule

FILE: hw/rtl/pfc_checker.sv
// Port-level checks for the packet framer, attached to the top level by bind.
// Stands alone; sees only the top level's channel signals.
module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic [4:0] byte_position,
  input logic       frame_end,
  input logic       end_of_packet,
  input logic [5:0] frame_meta,
  input logic       overflow_error,
  input logic       last_of_run
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(byte_position))
    else $error("result changed while stalled");

  // Present a result the cycle after a request is taken
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // Keep frame metadata zero away from the frame end
  a_meta_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_end |-> frame_meta == 6'd0)
    else $error("frame_meta set off the frame end");

  // Drop results carry only the error and run-end flags
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow_error |-> last_of_run && frame_byte == 8'h00 &&
      byte_position == 5'd0 && !frame_end && !end_of_packet)
    else $error("malformed drop result");

  // Close the run at the end of the final frame
  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_packet && frame_end |-> last_of_run)
    else $error("final frame ended before its run");

endmodule

bind packet_framer_with_crc pfc_checker u_pfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .frame_byte     (out_chan.frame_byte),
  .byte_position  (out_chan.byte_position),
  .frame_end      (out_chan.frame_end),
  .end_of_packet  (out_chan.end_of_packet),
  .frame_meta     (out_chan.frame_meta),
  .overflow_error (out_chan.overflow_error),
  .last_of_run    (out_chan.last_of_run)
);
